### src/quaternion_to_euler_angles_core_macros.svh
// assertion macros for the quaternion to euler angles core
// used by the checker bound to the top level; needs clk and rst_n in scope
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH

// implication checked at every clock edge outside reset
`define Q2E_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2e implication check failed");

// plain invariant checked at every clock edge outside reset
`define Q2E_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("q2e invariant check failed");

`endif

### src/q2e_pkg.sv
// shared types, constants and helpers of the quaternion to euler core
// no dependencies
`timescale 1ns / 1ps

package q2e_pkg;

  localparam int Q2E_CORDIC_STEPS = 16;
  localparam int Q2E_TAB_LEN      = 24;
  localparam int Q2E_SQ_CELLS     = 29;   // root bits of a 58-bit radicand
  localparam int Q2E_FW           = 35;   // front-end numerator/denominator width
  localparam int Q2E_SW           = 30;   // clamped sine width
  localparam int Q2E_VW           = 40;   // cordic vector width
  localparam int Q2E_NW           = 58;   // radicand width
  localparam int Q2E_RW           = 32;   // sqrt remainder width
  localparam int Q2E_AW           = 32;   // angle accumulator width

  localparam logic [Q2E_AW-1:0] ATAN_TAB [0:Q2E_TAB_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // payload riding along the sqrt chain
  typedef struct packed {
    logic signed [Q2E_FW-1:0] rn;
    logic signed [Q2E_FW-1:0] rd;
    logic signed [Q2E_FW-1:0] yn;
    logic signed [Q2E_FW-1:0] yd;
    logic signed [Q2E_SW-1:0] s;
    logic                     clamped;
  } side_t;

  // per-item flags riding along the cordic chain
  typedef struct packed {
    logic zr;
    logic zy;
    logic zp;
    logic clamped;
  } flags_t;

  function automatic int q2e_latency(input int steps);
    return 5 + Q2E_SQ_CELLS + steps;
  endfunction

  // round accumulator to 16-bit angle, wrapping
  function automatic logic signed [15:0] q2e_round(input logic [Q2E_AW-1:0] acc);
    logic [Q2E_AW-1:0] t;
    t = acc + 32'h0000_8000;
    return $signed(t[31:16]);
  endfunction

endpackage

### src/quaternion_to_euler_angles_core.sv
// top level of the quaternion to euler angles (z-y-x) core
// depends on q2e_pkg, q2e_sqrt_cell and q2e_cordic_cell
`timescale 1ns / 1ps

// Converts a unit quaternion (q14 fixed point) into roll, pitch and yaw
// (32768 = pi). Fully pipelined: a new quaternion transfer is taken every
// clock (busy is always low) and each result is flagged by a one-cycle
// out_valid. The receiver cannot stall, so results must be captured when
// out_valid is high. The pipeline holds three product/sum stages, a 29-cell
// square-root chain for the pitch cosine, one cordic set-up stage,
// CORDIC_STEPS rotation cells per angle and the output register.
// The pitch sine is clamped to +-1.0 and out_pitch_clamped reports it.

module quaternion_to_euler_angles_core
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = Q2E_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_pitch_clamped
);

  localparam int LAT = q2e_latency(CORDIC_STEPS);
  localparam logic signed [Q2E_FW-1:0] ONE_F = Q2E_FW'(64'sd268435456);
  localparam logic [Q2E_NW-1:0] ONE_SQ = Q2E_NW'(64'd1) << 56;

  // item valid line, one bit per pipeline stage
  logic [LAT-1:0] v_r;

  // stage 1: products
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, xz_r;

  // stage 2: atan2 operands and clamped sine
  side_t                    s2_r;
  logic signed [Q2E_FW-1:0] s_full;
  logic signed [Q2E_FW-1:0] rn_nxt, rd_nxt, yn_nxt, yd_nxt;

  // stage 3: radicand 1 - s^2
  logic [Q2E_SQ_CELLS-1:0]  s_mag;
  logic [Q2E_NW-1:0]        n_r;
  side_t                    s3_r;

  // sqrt chain
  logic [Q2E_NW-1:0]        sq_n    [0:Q2E_SQ_CELLS];
  logic [Q2E_RW-1:0]        sq_rem  [0:Q2E_SQ_CELLS];
  logic [Q2E_SQ_CELLS-1:0]  sq_root [0:Q2E_SQ_CELLS];
  side_t                    sq_side [0:Q2E_SQ_CELLS];

  // cordic lanes: 0 roll, 1 yaw, 2 pitch
  logic signed [Q2E_VW-1:0] px [0:2];
  logic signed [Q2E_VW-1:0] py [0:2];
  logic signed [Q2E_VW-1:0] cx [0:2][0:CORDIC_STEPS];
  logic signed [Q2E_VW-1:0] cy [0:2][0:CORDIC_STEPS];
  logic [Q2E_AW-1:0]        ca [0:2][0:CORDIC_STEPS];
  flags_t                   fl_r [0:CORDIC_STEPS];
  flags_t                   fl_nxt;

  logic signed [15:0]       pitch_rnd;

  assign busy = 1'b0;
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-2:0], start & ~busy};
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    wx_r <= in_quat_w * in_quat_x;
    yz_r <= in_quat_y * in_quat_z;
    xx_r <= in_quat_x * in_quat_x;
    yy_r <= in_quat_y * in_quat_y;
    wz_r <= in_quat_w * in_quat_z;
    xy_r <= in_quat_x * in_quat_y;
    zz_r <= in_quat_z * in_quat_z;
    wy_r <= in_quat_w * in_quat_y;
    xz_r <= in_quat_x * in_quat_z;
  end

  // stage 2
  always_comb begin
    rn_nxt = (Q2E_FW'(wx_r) + Q2E_FW'(yz_r)) <<< 1;
    yn_nxt = (Q2E_FW'(wz_r) + Q2E_FW'(xy_r)) <<< 1;
    rd_nxt = ONE_F - ((Q2E_FW'(xx_r) + Q2E_FW'(yy_r)) <<< 1);
    yd_nxt = ONE_F - ((Q2E_FW'(yy_r) + Q2E_FW'(zz_r)) <<< 1);
    s_full = (Q2E_FW'(wy_r) - Q2E_FW'(xz_r)) <<< 1;
  end

  always_ff @(posedge clk) begin
    s2_r.rn <= rn_nxt;
    s2_r.rd <= rd_nxt;
    s2_r.yn <= yn_nxt;
    s2_r.yd <= yd_nxt;
    if (s_full > ONE_F) begin
      s2_r.s       <= Q2E_SW'(ONE_F);
      s2_r.clamped <= 1'b1;
    end else if (s_full < -ONE_F) begin
      s2_r.s       <= Q2E_SW'(-ONE_F);
      s2_r.clamped <= 1'b1;
    end else begin
      s2_r.s       <= Q2E_SW'(s_full);
      s2_r.clamped <= 1'b0;
    end
  end

  // stage 3: cosine radicand
  always_comb begin
    s_mag = s2_r.s[Q2E_SW-1] ? Q2E_SQ_CELLS'(-s2_r.s) : Q2E_SQ_CELLS'(s2_r.s);
  end

  always_ff @(posedge clk) begin
    n_r  <= ONE_SQ - Q2E_NW'(s_mag) * Q2E_NW'(s_mag);
    s3_r <= s2_r;
  end

  assign sq_n[0]    = n_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3_r;

  for (genvar k = 0; k < Q2E_SQ_CELLS; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk    (clk),
      .n_i    (sq_n[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .n_o    (sq_n[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // cordic set-up: fold left half-plane vectors, flag zero vectors
  always_comb begin
    py[0] = Q2E_VW'(sq_side[Q2E_SQ_CELLS].rn);
    px[0] = Q2E_VW'(sq_side[Q2E_SQ_CELLS].rd);
    py[1] = Q2E_VW'(sq_side[Q2E_SQ_CELLS].yn);
    px[1] = Q2E_VW'(sq_side[Q2E_SQ_CELLS].yd);
    py[2] = Q2E_VW'(sq_side[Q2E_SQ_CELLS].s);
    px[2] = $signed({{(Q2E_VW-Q2E_SQ_CELLS){1'b0}}, sq_root[Q2E_SQ_CELLS]});
    fl_nxt.zr      = (px[0] == '0) && (py[0] == '0);
    fl_nxt.zy      = (px[1] == '0) && (py[1] == '0);
    fl_nxt.zp      = (px[2] == '0) && (py[2] == '0);
    fl_nxt.clamped = sq_side[Q2E_SQ_CELLS].clamped;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (px[l][Q2E_VW-1]) begin
        cx[l][0] <= -px[l];
        cy[l][0] <= -py[l];
        ca[l][0] <= 32'h8000_0000;
      end else begin
        cx[l][0] <= px[l];
        cy[l][0] <= py[l];
        ca[l][0] <= '0;
      end
    end
    fl_r[0] <= fl_nxt;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      fl_r[k+1] <= fl_r[k];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      q2e_cordic_cell #(.STEP(k)) u_cell (
        .clk   (clk),
        .x_i   (cx[l][k]),
        .y_i   (cy[l][k]),
        .acc_i (ca[l][k]),
        .x_o   (cx[l][k+1]),
        .y_o   (cy[l][k+1]),
        .acc_o (ca[l][k+1])
      );
    end
  end

  // output register: round, zero-vector override, pitch saturation
  assign pitch_rnd = q2e_round(ca[2][CORDIC_STEPS]);

  always_ff @(posedge clk) begin
    if (v_r[LAT-2]) begin
      out_roll_angle    <= fl_r[CORDIC_STEPS].zr ? 16'sd0 : q2e_round(ca[0][CORDIC_STEPS]);
      out_yaw_angle     <= fl_r[CORDIC_STEPS].zy ? 16'sd0 : q2e_round(ca[1][CORDIC_STEPS]);
      if (fl_r[CORDIC_STEPS].zp) begin
        out_pitch_angle <= 16'sd0;
      end else if (pitch_rnd > 16'sd16384) begin
        out_pitch_angle <= 16'sd16384;
      end else if (pitch_rnd < -16'sd16384) begin
        out_pitch_angle <= -16'sd16384;
      end else begin
        out_pitch_angle <= pitch_rnd;
      end
      out_pitch_clamped <= fl_r[CORDIC_STEPS].clamped;
    end
  end

endmodule

### src/q2e_sqrt_cell.sv
// one digit of a pipelined restoring square root
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_sqrt_cell
  import q2e_pkg::*;
(
  input  logic                     clk,
  input  logic [Q2E_NW-1:0]        n_i,
  input  logic [Q2E_RW-1:0]        rem_i,
  input  logic [Q2E_SQ_CELLS-1:0]  root_i,
  input  side_t                    side_i,
  output logic [Q2E_NW-1:0]        n_o,
  output logic [Q2E_RW-1:0]        rem_o,
  output logic [Q2E_SQ_CELLS-1:0]  root_o,
  output side_t                    side_o
);

  logic [Q2E_RW+1:0] rem_sh;
  logic [Q2E_RW+1:0] trial;
  logic              take;

  always_comb begin
    rem_sh = {rem_i, n_i[Q2E_NW-1 -: 2]};
    trial  = (Q2E_RW+2)'({root_i, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    n_o    <= {n_i[Q2E_NW-3:0], 2'b00};
    rem_o  <= take ? Q2E_RW'(rem_sh - trial) : Q2E_RW'(rem_sh);
    root_o <= {root_i[Q2E_SQ_CELLS-2:0], take};
    side_o <= side_i;
  end

endmodule

### src/q2e_cordic_cell.sv
// one micro-rotation of a vectoring cordic
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                     clk,
  input  logic signed [Q2E_VW-1:0] x_i,
  input  logic signed [Q2E_VW-1:0] y_i,
  input  logic [Q2E_AW-1:0]        acc_i,
  output logic signed [Q2E_VW-1:0] x_o,
  output logic signed [Q2E_VW-1:0] y_o,
  output logic [Q2E_AW-1:0]        acc_o
);

  logic signed [Q2E_VW-1:0] dx;
  logic signed [Q2E_VW-1:0] dy;

  always_comb begin
    dx = x_i >>> STEP;
    dy = y_i >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (!y_i[Q2E_VW-1]) begin
      x_o   <= x_i + dy;
      y_o   <= y_i - dx;
      acc_o <= acc_i + ATAN_TAB[STEP];
    end else begin
      x_o   <= x_i - dy;
      y_o   <= y_i + dx;
      acc_o <= acc_i - ATAN_TAB[STEP];
    end
  end

endmodule

### src/q2e_checker.sv
// port-level checks for the quaternion to euler angles core, with its bind
// depends on q2e_pkg and quaternion_to_euler_angles_core_macros.svh
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_core_macros.svh"

module q2e_checker
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = Q2E_CORDIC_STEPS
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_pitch_angle
);

  localparam int LAT = q2e_latency(CORDIC_STEPS);

  logic pitch_ok;

  assign pitch_ok = (out_pitch_angle <= 16'sd16384) && (out_pitch_angle >= -16'sd16384);

  // fully pipelined core never refuses a transfer
  `Q2E_ASSERT_ALWAYS(a_never_busy, !busy)
  // every result traces back to a start delayed by the core latency (q2e_latency)
  `Q2E_ASSERT_IMP(a_result_has_start, out_valid, $past(start, LAT))
  // pitch stays within +-pi/2
  `Q2E_ASSERT_IMP(a_pitch_range, out_valid, pitch_ok)

endmodule

bind quaternion_to_euler_angles_core q2e_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_q2e_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_pitch_angle (out_pitch_angle)
);
